// ===== rtl/i4gsdp_pkg.sv =====
// Shared types for the int4 group-scaled dot product unit.
// No dependencies.
`default_nettype none

package i4gsdp_pkg;

	localparam int GACC_W = 19;
	localparam int ASUM_W = 15;

	// one finished group, handed from the integer front to the float back
	typedef struct packed {
		logic [GACC_W-1:0] diff;
		logic [31:0]       act_scale;
		logic [15:0]       weight_scale;
		logic              row_end;
	} group_item_t;

	// handshake between the queue and its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/i4gsdp_queue.sv =====
// Short FIFO of finished groups between front and back.
// Depends on i4gsdp_pkg.
`default_nettype none

module i4gsdp_queue
	import i4gsdp_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire group_item_t   wr_item,
	input  wire logic          rd_en,
	output      group_item_t   rd_item,
	output      queue_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_item_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/i4gsdp_front.sv =====
// Integer front end: nibble MAC per byte, offset correction at group or row end.
// Depends on i4gsdp_pkg.
`default_nettype none

module i4gsdp_front
	import i4gsdp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output      logic                 full,
	input  wire logic [7:0]           weight_byte,
	input  wire logic signed [7:0]    act_first,
	input  wire logic signed [7:0]    act_second,
	input  wire logic                 group_end,
	input  wire logic                 row_end,
	input  wire logic [31:0]          act_scale,
	input  wire logic [15:0]          weight_scale,
	input  wire logic signed [ASUM_W-1:0] act_group_sum,
	output      logic                 q_push,
	output      group_item_t          q_item,
	input  wire queue_status_t        q_status
);

	logic [GACC_W-1:0] gacc_q;
	logic signed [12:0] prod_lo;
	logic signed [12:0] prod_hi;
	logic [GACC_W-1:0]  gsum;
	logic               accept;
	logic               grp_done;

	assign full     = q_status.full;
	assign accept   = push && !full;
	assign grp_done = group_end || row_end;

	assign prod_lo = $signed({1'b0, weight_byte[3:0]}) * act_first;
	assign prod_hi = $signed({1'b0, weight_byte[7:4]}) * act_second;
	assign gsum    = gacc_q + GACC_W'(prod_lo) + GACC_W'(prod_hi);

	assign q_push              = accept && grp_done;
	assign q_item.diff         = gsum - GACC_W'($signed({act_group_sum, 3'b000}));
	assign q_item.act_scale    = act_scale;
	assign q_item.weight_scale = weight_scale;
	assign q_item.row_end      = row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gacc_q <= '0;
		end else if (accept) begin
			gacc_q <= grp_done ? '0 : gsum;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/i4gsdp_back.sv =====
// Float back end: two scale multiplies and the row accumulate, on one
// shared multiply/add, normalize and round datapath. Depends on i4gsdp_pkg.
`default_nettype none

module i4gsdp_back
	import i4gsdp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire group_item_t   q_item,
	input  wire queue_status_t q_status,
	output      logic          q_pop,
	input  wire logic          pop,
	output      logic          empty,
	output      logic [31:0]   dot_value
);

	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic               zero;
		logic [23:0]        man;
		logic signed [10:0] expo;
		logic [31:0]        bits;
	} fp_unpk_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_OP   = 5'b00010,
		ST_NORM = 5'b00100,
		ST_RND  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	localparam logic [1:0] PH_SCALE_A = 2'd0;
	localparam logic [1:0] PH_SCALE_W = 2'd1;
	localparam logic [1:0] PH_ACCUM   = 2'd2;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [30:0] INF_MAG      = 31'h7F80_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	function automatic fp_unpk_t unpk_f32(input logic [31:0] b);
		fp_unpk_t u;
		u.sign = b[31];
		u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		u.zero = (b[30:0] == '0);
		u.man  = {b[30:23] != 8'h00, b[22:0]};
		u.expo = (b[30:23] == 8'h00) ? 11'sd1 : $signed({3'b000, b[30:23]});
		u.bits = b;
		return u;
	endfunction

	// half: zero, subnormal as man * 2^-24, everything else rebiased
	function automatic fp_unpk_t unpk_f16(input logic [15:0] h);
		fp_unpk_t u;
		u.sign = h[15];
		u.nan  = 1'b0;
		u.inf  = 1'b0;
		u.zero = (h[14:0] == '0);
		u.man  = (h[14:10] == 5'd0) ? {14'd0, h[9:0]} : {1'b1, h[9:0], 13'd0};
		u.expo = (h[14:10] == 5'd0) ? 11'sd126 : $signed({6'd0, h[14:10]}) + 11'sd112;
		u.bits = '0;
		return u;
	endfunction

	// integer, exact: value = magnitude * 2^0
	function automatic fp_unpk_t unpk_int(input logic [GACC_W-1:0] d);
		fp_unpk_t u;
		logic [GACC_W-1:0] mag;
		mag    = d[GACC_W-1] ? (~d + 1'b1) : d;
		u.sign = d[GACC_W-1];
		u.nan  = 1'b0;
		u.inf  = 1'b0;
		u.zero = (d == '0);
		u.man  = 24'(mag);
		u.expo = 11'sd150;
		u.bits = '0;
		return u;
	endfunction

	state_t      state_q;
	logic [1:0]  phase_q;
	group_item_t cur_q;
	logic [31:0] t_q;
	logic [31:0] acc_q;
	logic [31:0] out_q;
	logic        out_valid_q;

	logic [49:0]        r_s1;
	logic signed [10:0] k_s1;
	logic               sign_s1;
	logic [47:0]        m_s2;
	logic signed [10:0] er_s2;
	logic               sign_s2;

	// operand select and first arithmetic step
	fp_unpk_t    ua, ub, big, sml;
	logic        op_sign;
	logic [49:0] op_r;
	logic signed [10:0] op_k;
	logic        spec_hit;
	logic [31:0] spec_bits;
	logic [47:0] prod;
	logic        a_ge;
	logic [10:0] ediff;
	logic [5:0]  ash;
	logic [49:0] sm50, bg50, sm_al;

	always_comb begin
		case (phase_q)
			PH_SCALE_A: begin
				ua = unpk_int(cur_q.diff);
				ub = unpk_f32(cur_q.act_scale);
			end
			PH_SCALE_W: begin
				ua = unpk_f32(t_q);
				ub = unpk_f16(cur_q.weight_scale);
			end
			default: begin
				ua = unpk_f32(acc_q);
				ub = unpk_f32(t_q);
			end
		endcase

		prod  = ua.man * ub.man;
		a_ge  = {ua.expo, ua.man} >= {ub.expo, ub.man};
		big   = a_ge ? ua : ub;
		sml   = a_ge ? ub : ua;
		ediff = 11'(big.expo - sml.expo);
		ash   = (ediff > 11'd50) ? 6'd50 : ediff[5:0];
		sm50  = {1'b0, sml.man, 25'd0};
		bg50  = {1'b0, big.man, 25'd0};
		sm_al = (sm50 >> ash) | {49'd0, |(sm50 & ((50'd1 << ash) - 50'd1))};

		spec_hit  = 1'b0;
		spec_bits = '0;
		op_sign   = ua.sign ^ ub.sign;
		op_r      = {prod, 2'b00};
		op_k      = ua.expo + ub.expo - 11'sd126;

		if (ua.nan) begin
			spec_hit  = 1'b1;
			spec_bits = ua.bits | QUIET_BIT;
		end else if (ub.nan) begin
			spec_hit  = 1'b1;
			spec_bits = ub.bits | QUIET_BIT;
		end else if (phase_q != PH_ACCUM) begin
			if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
				spec_hit  = 1'b1;
				spec_bits = QNAN_DEFAULT;
			end else if (ua.inf || ub.inf) begin
				spec_hit  = 1'b1;
				spec_bits = {op_sign, INF_MAG};
			end else if (ua.zero || ub.zero) begin
				spec_hit  = 1'b1;
				spec_bits = {op_sign, 31'd0};
			end
		end else begin
			op_sign = big.sign;
			op_r    = (ua.sign ^ ub.sign) ? bg50 - sm_al : bg50 + sm_al;
			op_k    = big.expo + 11'sd1;
			if (ua.inf && ub.inf && (ua.sign != ub.sign)) begin
				spec_hit  = 1'b1;
				spec_bits = QNAN_DEFAULT;
			end else if (ua.inf) begin
				spec_hit  = 1'b1;
				spec_bits = ua.bits;
			end else if (ub.inf) begin
				spec_hit  = 1'b1;
				spec_bits = ub.bits;
			end else if (ua.zero && ub.zero) begin
				spec_hit  = 1'b1;
				spec_bits = {ua.sign & ub.sign, 31'd0};
			end else if (ua.zero) begin
				spec_hit  = 1'b1;
				spec_bits = ub.bits;
			end else if (ub.zero) begin
				spec_hit  = 1'b1;
				spec_bits = ua.bits;
			end else if (op_r == '0) begin
				spec_hit  = 1'b1;
				spec_bits = '0;
			end
		end
	end

	// leading-one search and normalize
	logic [5:0]  lz;
	logic [49:0] r_norm;
	always_comb begin
		lz = '0;
		for (int i = 0; i < 50; i++) begin
			if (r_s1[i]) lz = 6'(49 - i);
		end
		r_norm = r_s1 << lz;
	end

	// round to nearest even, with gradual underflow
	logic signed [10:0] shv;
	logic [5:0]  rsh;
	logic [47:0] mm;
	logic [30:0] base, rres;
	logic        rup;
	logic [31:0] rnd_bits;
	always_comb begin
		shv = 11'sd1 - er_s2;
		rsh = (shv > 11'sd48) ? 6'd48 : shv[5:0];
		if (er_s2 >= 11'sd1) begin
			mm   = m_s2;
			base = {er_s2[7:0], m_s2[46:24]};
		end else begin
			mm   = (m_s2 >> rsh) | {47'd0, |(m_s2 & ((48'd1 << rsh) - 48'd1))};
			base = {8'd0, mm[46:24]};
		end
		rup  = mm[23] && ((|mm[22:0]) || mm[24]);
		rres = base + 31'(rup);
		rnd_bits = (er_s2 > 11'sd254) ? {sign_s2, INF_MAG} : {sign_s2, rres};
	end

	logic        wb_en;
	logic [31:0] wb_bits;
	assign wb_en   = ((state_q == ST_OP) && spec_hit) || (state_q == ST_RND);
	assign wb_bits = (state_q == ST_RND) ? rnd_bits : spec_bits;

	assign q_pop     = (state_q == ST_IDLE) && !q_status.empty;
	assign empty     = !out_valid_q;
	assign dot_value = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (state_q == ST_OP) begin
			r_s1    <= op_r;
			k_s1    <= op_k;
			sign_s1 <= op_sign;
		end
		if (state_q == ST_NORM) begin
			m_s2    <= r_norm[49:2] | {47'd0, |r_norm[1:0]};
			er_s2   <= k_s1 - $signed({5'd0, lz});
			sign_s2 <= sign_s1;
		end
		if (wb_en && (phase_q != PH_ACCUM)) t_q <= wb_bits;
		if ((state_q == ST_EMIT) && !out_valid_q) out_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SCALE_A;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						phase_q <= PH_SCALE_A;
						state_q <= ST_OP;
					end
				end
				// a write-back picks the next state below
				ST_OP, ST_RND: if (!wb_en) state_q <= ST_NORM;
				ST_NORM: state_q <= ST_RND;
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (wb_en) begin
				case (phase_q)
					PH_SCALE_A: begin
						phase_q <= PH_SCALE_W;
						state_q <= ST_OP;
					end
					PH_SCALE_W: begin
						phase_q <= PH_ACCUM;
						state_q <= ST_OP;
					end
					default: begin
						acc_q   <= wb_bits;
						state_q <= cur_q.row_end ? ST_EMIT : ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/int4_group_scaled_dot_product_unit.sv =====
// Top level of the int4 group-scaled dot product unit.
// Depends on i4gsdp_pkg, i4gsdp_front, i4gsdp_queue, i4gsdp_back.
`default_nettype none

// One weight byte (two int4 weights) is taken per cycle; the integer MAC
// runs at that rate with no stall except when the group queue is full.
// Each group end or row end enqueues one entry of QUEUE_DEPTH; the float
// back end loads a group, then scales it by the activation scale, scales
// by the weight scale and accumulates, each as multiply/add, normalize,
// round on one shared datapath (fewer steps when an operand is zero, inf
// or NaN), and at row end hands the row sum to the result register once
// it is empty. It pops the next group only when back in idle. Results follow
// IEEE single precision, round to nearest even, subnormals kept.

module int4_group_scaled_dot_product_unit
	import i4gsdp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output      logic                     full,
	input  wire logic [7:0]               weight_byte,
	input  wire logic signed [7:0]        act_first,
	input  wire logic signed [7:0]        act_second,
	input  wire logic                     group_end,
	input  wire logic                     row_end,
	input  wire logic [31:0]              act_scale,
	input  wire logic [15:0]              weight_scale,
	input  wire logic signed [ASUM_W-1:0] act_group_sum,
	output      logic                     empty,
	input  wire logic                     pop,
	output      logic [31:0]              dot_value
);

	logic          q_push;
	logic          q_pop;
	group_item_t   q_wr_item;
	group_item_t   q_rd_item;
	queue_status_t q_status;

	i4gsdp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.weight_byte  (weight_byte),
		.act_first    (act_first),
		.act_second   (act_second),
		.group_end    (group_end),
		.row_end      (row_end),
		.act_scale    (act_scale),
		.weight_scale (weight_scale),
		.act_group_sum(act_group_sum),
		.q_push       (q_push),
		.q_item       (q_wr_item),
		.q_status     (q_status)
	);

	i4gsdp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_item(q_wr_item),
		.rd_en  (q_pop),
		.rd_item(q_rd_item),
		.status (q_status)
	);

	i4gsdp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_rd_item),
		.q_status (q_status),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.dot_value(dot_value)
	);

	// a group is never written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("group queue overflow");

	// the back end never takes an entry that is not there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("group queue underflow");

	// a queue entry written while empty is visible in the next cycle
	a_fill_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_status.empty) |=> !q_status.empty)
		else $error("queued group lost");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for int4_group_scaled_dot_product_unit.
// Depends on i4gsdp_pkg and the unit RTL. It uses a directed table, then random rows, and
// checks each result against a table value or a float32 predictor built on real arithmetic.
`timescale 1ns / 100ps

module tb_top;
	import i4gsdp_pkg::*;

	typedef struct {
		logic [7:0]        wb;
		logic signed [7:0] a1;
		logic signed [7:0] a2;
		logic              ge;
		logic              re;
		logic [31:0]       ascale;
		logic [15:0]       wscale;
		logic [ASUM_W-1:0] asum;
		logic              has_exp;
		logic [31:0]       exp_val;
	} byte_item_t;

	localparam int IDLE_PCT   = 24;
	localparam int WD_LIMIT   = 5000;
	localparam int HOLD_LEN   = 400;
	localparam int N_RANDOM   = 750;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] weight_byte;
	logic signed [7:0] act_first;
	logic signed [7:0] act_second;
	logic group_end;
	logic row_end;
	logic [31:0] act_scale;
	logic [15:0] weight_scale;
	logic signed [ASUM_W-1:0] act_group_sum;
	logic empty;
	logic pop;
	logic [31:0] dot_value;

	// predictor state
	logic [GACC_W-1:0] grp_sum;
	logic [31:0]       row_sum;
	logic [31:0]       dot_queue[$];

	int errors;
	int tx_count;
	int rx_count;
	int idle_cycles;
	bit held;

	int_group_dummy_guard : assert property (@(posedge clk) 1);

	int4_group_scaled_dot_product_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.weight_byte(weight_byte), .act_first(act_first), .act_second(act_second),
		.group_end(group_end), .row_end(row_end), .act_scale(act_scale),
		.weight_scale(weight_scale), .act_group_sum(act_group_sum),
		.empty(empty), .pop(pop), .dot_value(dot_value)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// float32 <-> real; real ops on float32 operands round once to double, then to float32,
	// which is exact enough for single multiply and add
	function automatic real f32_to_real(input logic [31:0] f);
		real r;
		if (f[30:23] == 8'hFF) begin
			if (f[22:0] != 0)
				return $bitstoreal(64'h7FF8000000000000);
			return $bitstoreal({f[31], 63'h7FF0000000000000});
		end
		if (f[30:23] == 0) begin
			if (f[22:0] == 0)
				return $bitstoreal({f[31], 63'h0});
			r = real'(f[22:0]) * $bitstoreal(64'h36A0000000000000);
			return f[31] ? -r : r;
		end
		return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'h0});
	endfunction

	function automatic logic [31:0] real_to_f32(input real r);
		logic [63:0] b;
		logic [63:0] sig;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		int ex;
		int sh;
		int biased;
		b = $realtobits(r);
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 0) ? 32'h7FC00000 : {b[63], 31'h7F800000};
		if (b[62:52] == 0)
			return {b[63], 31'h0};
		ex = int'(b[62:52]) - 1023;
		sig = {11'h0, 1'b1, b[51:0]};
		sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (sh > 60)
			return {b[63], 31'h0};
		kept = sig >> sh;
		rem = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 1;
		if (ex < -126)
			return {b[63], kept[30:0]};
		biased = ex + 127;
		if (kept[24]) begin
			kept = kept >> 1;
			biased++;
		end
		if (biased >= 255)
			return {b[63], 31'h7F800000};
		return {b[63], biased[7:0], kept[22:0]};
	endfunction

	function automatic logic [31:0] half_to_f32(input logic [15:0] h);
		real r;
		if (h[14:10] == 0) begin
			if (h[9:0] == 0)
				return {h[15], 31'h0};
			r = real'(h[9:0]) * $bitstoreal(64'h3E70000000000000);
			return real_to_f32(h[15] ? -r : r);
		end
		return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'h0};
	endfunction

	// advance the predictor by one accepted byte; has_dot set on row end
	task automatic predict_byte(input byte_item_t it, output bit has_dot,
			output logic [31:0] dot);
		logic signed [GACC_W-1:0] prod;
		logic signed [GACC_W-1:0] diff;
		logic [31:0] t;
		prod = $signed({1'b0, it.wb[3:0]}) * it.a1 + $signed({1'b0, it.wb[7:4]}) * it.a2;
		grp_sum = grp_sum + prod;
		has_dot = 1'b0;
		dot = '0;
		if (it.ge || it.re) begin
			diff = grp_sum - (GACC_W'($signed(it.asum)) <<< 3);
			t = real_to_f32(real'(diff));
			t = real_to_f32(f32_to_real(t) * f32_to_real(it.ascale));
			t = real_to_f32(f32_to_real(t) * f32_to_real(half_to_f32(it.wscale)));
			row_sum = real_to_f32(f32_to_real(row_sum) + f32_to_real(t));
			grp_sum = '0;
		end
		if (it.re) begin
			has_dot = 1'b1;
			dot = row_sum;
			row_sum = 32'h0;
		end
	endtask

	function automatic bit take_idle(input int cnt, input int lo, input int hi);
		if (cnt >= lo && cnt < hi)
			return 1'b0;
		return $urandom_range(99, 0) < IDLE_PCT;
	endfunction

	task automatic send_byte(input byte_item_t it);
		bit has_dot;
		logic [31:0] dot;
		while (take_idle(tx_count, 300, 420)) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		weight_byte <= it.wb;
		act_first <= it.a1;
		act_second <= it.a2;
		group_end <= it.ge;
		row_end <= it.re;
		act_scale <= it.ascale;
		weight_scale <= it.wscale;
		act_group_sum <= it.asum;
		do
			@(posedge clk);
		while (full);
		tx_count++;
		predict_byte(it, has_dot, dot);
		if (has_dot)
			dot_queue.push_back(it.has_exp ? it.exp_val : dot);
	endtask

	function automatic byte_item_t mk(input logic [7:0] wb, input int a1, input int a2,
			input bit ge, input bit re, input logic [31:0] asc, input logic [15:0] wsc,
			input int asum, input bit has_exp, input logic [31:0] exp_val);
		byte_item_t it;
		it.wb = wb;
		it.a1 = 8'(a1);
		it.a2 = 8'(a2);
		it.ge = ge;
		it.re = re;
		it.ascale = asc;
		it.wscale = wsc;
		it.asum = ASUM_W'(asum);
		it.has_exp = has_exp;
		it.exp_val = exp_val;
		return it;
	endfunction

	function automatic logic [31:0] rand_ascale();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(9, 0) != 0)
			v[30:23] = 8'($urandom_range(140, 100));
		return v;
	endfunction

	function automatic logic [15:0] rand_wscale();
		logic [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(9, 0) != 0)
			v[14:10] = 5'($urandom_range(20, 8));
		return v;
	endfunction

	// receive side: random pop, one long hold to fill the unit, and a window of constant pop
	initial begin
		int hold;
		int cyc;
		hold = 0;
		cyc = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && tx_count > 100) begin
				held = 1'b1;
				hold = HOLD_LEN;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (cyc >= 1500 && cyc < 1800) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	// result check
	always @(posedge clk) begin
		logic [31:0] want;
		bit ok;
		if (arst_n && pop && !empty) begin
			rx_count++;
			if (dot_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected dot_value %h", dot_value);
			end else begin
				want = dot_queue.pop_front();
				if (want[30:23] == 8'hFF && want[22:0] != 0)
					ok = (dot_value[30:23] == 8'hFF && dot_value[22:0] != 0);
				else
					ok = (dot_value === want);
				if (!ok) begin
					errors++;
					if (errors <= 10)
						$display("dot_value mismatch: expected %h got %h", want, dot_value);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		byte_item_t dir[$];
		byte_item_t it;
		int n;
		int groups;
		int len;
		errors = 0;
		tx_count = 0;
		rx_count = 0;
		idle_cycles = 0;
		held = 1'b0;
		grp_sum = '0;
		row_sum = 32'h0;
		arst_n = 1'b0;
		push = 1'b0;
		weight_byte = '0;
		act_first = '0;
		act_second = '0;
		group_end = 1'b0;
		row_end = 1'b0;
		act_scale = '0;
		weight_scale = '0;
		act_group_sum = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir.push_back(mk(8'h00, 0, 0, 1, 1, 32'h3F800000, 16'h3C00, 0, 1, 32'h00000000));
		dir.push_back(mk(8'h11, 1, 1, 1, 1, 32'h3F800000, 16'h3C00, 0, 1, 32'h40000000));
		dir.push_back(mk(8'hFF, -128, -128, 1, 1, 32'h3F800000, 16'h3C00, 0, 1, 32'hC5700000));
		dir.push_back(mk(8'hFF, 127, 127, 1, 1, 32'h3F800000, 16'h3C00, 0, 0, 0));
		dir.push_back(mk(8'h00, 0, 0, 1, 1, 32'h3F800000, 16'h3C00, -8192, 1, 32'h47800000));
		dir.push_back(mk(8'h00, 0, 0, 1, 1, 32'h3F800000, 16'h3C00, 8192, 1, 32'hC7800000));
		// half subnormal, negative zero, inf and nan halves
		dir.push_back(mk(8'h11, 1, 3, 1, 1, 32'h3F800000, 16'h0001, 0, 0, 0));
		dir.push_back(mk(8'h13, -7, 3, 1, 1, 32'h40400000, 16'h8000, 5, 0, 0));
		dir.push_back(mk(8'h21, 5, 9, 1, 1, 32'h3F800000, 16'h7C00, 0, 0, 0));
		dir.push_back(mk(8'h21, 5, 9, 1, 1, 32'h3F800000, 16'hFE00, 0, 0, 0));
		// inf and nan activation scale
		dir.push_back(mk(8'h21, 5, 9, 1, 1, 32'h7F800000, 16'h3C00, 0, 0, 0));
		dir.push_back(mk(8'h21, 5, 9, 1, 1, 32'h7FC00000, 16'h3C00, 0, 0, 0));
		// two groups; row end without group end
		dir.push_back(mk(8'h21, 3, -5, 1, 0, 32'h3E800000, 16'h4000, 2, 0, 0));
		dir.push_back(mk(8'h01, 2, 0, 0, 1, 32'h3F000000, 16'hB800, -1, 0, 0));
		// act sum extremes, at both ends of the 15-bit signed range
		dir.push_back(mk(8'hF0, 0, 127, 1, 0, 32'h3F800000, 16'h3C00, -16384, 0, 0));
		dir.push_back(mk(8'h0F, -128, 0, 1, 1, 32'h3F800000, 16'h3C00, 16383, 0, 0));
		// tiny scale and overflow to inf
		dir.push_back(mk(8'h11, 1, 1, 1, 1, 32'h00000001, 16'h3C00, 0, 0, 0));
		dir.push_back(mk(8'hFF, 127, 127, 1, 1, 32'h7F7FFFFF, 16'h7BFF, 0, 0, 0));
		foreach (dir[i])
			send_byte(dir[i]);

		n = 0;
		while (n < N_RANDOM) begin
			groups = $urandom_range(4, 1);
			for (int g = 0; g < groups; g++) begin
				case ($urandom_range(19, 0))
					0: len = 32;
					1: len = $urandom_range(200, 100);
					default: len = $urandom_range(8, 1);
				endcase
				for (int k = 0; k < len; k++) begin
					it = mk(8'($urandom), int'($urandom_range(255, 0)) - 128,
						int'($urandom_range(255, 0)) - 128, 0, 0,
						$urandom, 16'($urandom), $urandom_range(32767, 0), 0, 0);
					if (k == len - 1) begin
						it.ascale = rand_ascale();
						it.wscale = rand_wscale();
						if ($urandom_range(9, 0) != 0)
							it.asum = ASUM_W'(int'($urandom_range(16384, 0)) - 8192);
						if (g == groups - 1) begin
							it.re = 1'b1;
							it.ge = $urandom_range(1, 0);
						end else begin
							it.ge = 1'b1;
						end
					end
					send_byte(it);
					n++;
				end
			end
		end
		push <= 1'b0;

		while (dot_queue.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
